// ----- design/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// Holds the request, result and entry structs and the command and status codes.
// No dependencies; every other file in the design imports this package.
`default_nettype none

package spq_pkg;

  localparam int SPQ_CAPACITY = 16;
  localparam int PRIO_W = 16;
  localparam int DATA_W = 32;
  localparam int OCC_W = 5;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic signed [PRIO_W-1:0] prio_in;
    logic signed [DATA_W-1:0] item_in;
  } spq_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_item;
    logic signed [PRIO_W-1:0] front_prio;
    logic signed [DATA_W-1:0] rear_item;
    logic [OCC_W-1:0] occupancy;
    logic is_empty;
    logic [1:0] status;
  } spq_rsp_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
  } spq_entry_t;

  // Operation broadcast to every cell of the chain at once.
  typedef struct packed {
    logic ins;
    logic rem;
    spq_entry_t key;
  } spq_op_t;

endpackage

`default_nettype wire

// ----- design/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue: a chain of compare-and-shift cells.
// Depends on spq_pkg and spq_cell.
//
// Use: drive req (cmd, prio_in, item_in) and raise start for one cycle; the item
// is taken at a rising edge where start is high and busy is low. busy stays low,
// so a new item may be started in every cycle. Each item gives exactly one result
// on rsp, marked by done, in the cycle after the item is taken; throughput is
// one item per cycle. All cells compare against the new priority in parallel
// and shift by one place in the same edge, so an insert, a remove or a query
// is done at the edge that takes it, whatever the fill level.
// The result shows the front entry, the rear entry and the occupancy after the
// command, with a status of ok, underflow (remove while empty, nothing changes)
// or overflow (insert while full, the new entry is dropped). Front and rear read
// zero while the queue is empty. The receiver cannot stall: done marks each result
// for one cycle only. Reset empties the queue at once; cell contents are left as
// they are and are never shown before being written.
`default_nettype none

module sorted_priority_queue_top #(
  parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire spq_pkg::spq_req_t req,
  output logic                   busy,
  output logic                   done,
  output spq_pkg::spq_rsp_t      rsp
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [1:0]          status;
  logic [1:0]          status_next;
  logic signed [DATA_W-1:0] rear;
  logic signed [DATA_W-1:0] rear_next;
  logic                accept;
  logic                full;
  logic                empty;
  spq_op_t             op;
  spq_entry_t          cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_ge;
  logic [CAPACITY-1:0] cell_lower;

  assign busy = 1'b0;
  assign accept = start && !busy;
  assign full = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  assign op.ins = accept && (req.cmd == CMD_INSERT) && !full;
  assign op.rem = accept && (req.cmd == CMD_REMOVE) && !empty;
  assign op.key.prio = req.prio_in;
  assign op.key.data = req.item_in;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_entry_t left_entry;
    spq_entry_t right_entry;
    logic       left_ge;

    if (i == 0) begin : g_head
      assign left_entry = op.key;
      assign left_ge = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_ge = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell #(
      .IDX  (i),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .count      (count),
      .left_entry (left_entry),
      .left_ge    (left_ge),
      .right_entry(right_entry),
      .entry      (cell_entry[i]),
      .ge         (cell_ge[i]),
      .lower      (cell_lower[i])
    );
  end

  // The rear only changes on an insert that lands behind every held entry; a remove
  // shifts every entry forward by one place, so the last entry stays the last.
  always_comb begin
    rear_next = rear;
    if (op.ins && !(|cell_lower)) begin
      rear_next = req.item_in;
    end
  end

  always_comb begin
    count_next = count;
    status_next = ST_OK;
    if (op.ins) begin
      count_next = count + CNT_W'(1);
    end else if (op.rem) begin
      count_next = count - CNT_W'(1);
    end
    if (accept && (req.cmd == CMD_INSERT) && full) begin
      status_next = ST_OVER;
    end else if (accept && (req.cmd == CMD_REMOVE) && empty) begin
      status_next = ST_UNDER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done <= 1'b0;
    end else begin
      count <= count_next;
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    rear <= rear_next;
    status <= status_next;
  end

  always_comb begin
    rsp.occupancy = OCC_W'(count);
    rsp.is_empty = empty;
    rsp.status = status;
    if (empty) begin
      rsp.front_item = '0;
      rsp.front_prio = '0;
      rsp.rear_item = '0;
    end else begin
      rsp.front_item = cell_entry[0].data;
      rsp.front_prio = cell_entry[0].prio;
      rsp.rear_item = rear;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("fill count moved without an item");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_OVER) |-> full)
    else $error("overflow reported while not full");

  a_under_empty: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_UNDER) |-> empty)
    else $error("underflow reported while not empty");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result without an accepted item");

endmodule

`default_nettype wire

// ----- design/spq_cell.sv -----
// One cell of the sorted chain: holds a single entry and its place in the order.
// Depends on spq_pkg for the entry and operation structs.
`default_nettype none

module spq_cell #(
  parameter int IDX = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                clk,
  input  wire spq_pkg::spq_op_t    op,
  input  wire logic [CNT_W-1:0]    count,
  input  wire spq_pkg::spq_entry_t left_entry,
  input  wire logic                left_ge,
  input  wire spq_pkg::spq_entry_t right_entry,
  output spq_pkg::spq_entry_t      entry,
  output logic                     ge,
  output logic                     lower
);
  import spq_pkg::*;

  logic       occ;
  spq_entry_t entry_next;

  // The cell is in use when its place lies below the fill count.
  assign occ = (CNT_W'(IDX) < count);
  assign ge = occ && (entry.prio >= op.key.prio);
  assign lower = occ && !ge;

  // On insert an entry stays put when it outranks or ties the new one; the first
  // cell that does not takes the new entry, and the cells behind it shift back.
  always_comb begin
    entry_next = entry;
    if (op.ins) begin
      if (ge) begin
        entry_next = entry;
      end else if (left_ge) begin
        entry_next = op.key;
      end else begin
        entry_next = left_entry;
      end
    end else if (op.rem) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire
